[rtl/core/odcs_pkg.sv]
`default_nettype none
package odcs_pkg;
   localparam logic [2:0] KIND_V1 = 3'd0;
   localparam logic [2:0] KIND_V2 = 3'd1;
   localparam logic [2:0] KIND_VC = 3'd2;
   localparam logic [2:0] KIND_KEI = 3'd3;
   localparam logic [2:0] KIND_KEF = 3'd4;
   localparam logic [2:0] KIND_LOSS = 3'd5;
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_MISSING = 2'd1;
   localparam logic [1:0] ST_ZERO_MASS = 2'd2;

   typedef struct packed {
      logic        mode;
      logic        err;
      logic [1:0]  status;
      logic [31:0] mass_a;
      logic [31:0] mass_b;
      logic [31:0] speed_a;
      logic [31:0] speed_b;
   } job_type;
endpackage
`default_nettype wire

[rtl/core/one_dim_collision_solver.sv]
`default_nettype none
// One-dimensional two-body collision solver.
// Input: pulse start with req_* fields while busy is low; the word is taken
// at that edge. Output: a burst of results, each shown for one cycle with
// rsp_valid; rsp_last marks the final one. The receiver cannot stall.
// Elastic: v1, v2, initial KE, final KE. Inelastic: combined v, initial KE,
// final KE, loss. Missing data or zero total mass: one result with status.
// After the word is taken: two multiply stages, a 68-bit restoring divider
// at four quotient bits a cycle, energy stages, then one result a cycle.
// The back end works on one word at a time, its pace set mainly by the
// divider; a queued word waits in the front register so a new start can
// be taken while the back end works. Error words skip the arithmetic.
// Reset clears both control sections; no word is held after reset.
module one_dim_collision_solver #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_mode,
   input  wire logic [31:0] req_mass_a,
   input  wire logic [31:0] req_mass_b,
   input  wire logic [31:0] req_speed_a,
   input  wire logic [31:0] req_speed_b,
   input  wire logic        req_all_given,
   output logic             rsp_valid,
   output logic [2:0]       rsp_kind,
   output logic [63:0]      rsp_amount,
   output logic [1:0]       rsp_status,
   output logic             rsp_last
);
   import odcs_pkg::*;
   job_type job;
   logic job_valid, job_take;

   odcs_front u_front (
      .clock, .reset, .start, .busy, .req_mode, .req_mass_a, .req_mass_b,
      .req_speed_a, .req_speed_b, .req_all_given, .job, .job_valid, .job_take);

   odcs_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock, .reset, .job, .job_valid, .job_take, .rsp_valid, .rsp_kind,
      .rsp_amount, .rsp_status, .rsp_last);
endmodule
`default_nettype wire

[rtl/core/odcs_front.sv]
`default_nettype none
// Classifies an incoming word into an error or a solve job; one-entry queue to the back.
module odcs_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire logic            req_mode,
   input  wire logic [31:0]     req_mass_a,
   input  wire logic [31:0]     req_mass_b,
   input  wire logic [31:0]     req_speed_a,
   input  wire logic [31:0]     req_speed_b,
   input  wire logic            req_all_given,
   output odcs_pkg::job_type    job,
   output logic                 job_valid,
   input  wire logic            job_take
);
   import odcs_pkg::*;
   logic    valid_ff, valid_in;
   job_type job_ff, job_in;
   logic [32:0] total;

   assign total = {1'b0, req_mass_a} + {1'b0, req_mass_b};
   assign busy = valid_ff && !job_take;
   assign job = job_ff;
   assign job_valid = valid_ff;

   always_comb begin
      job_in = job_ff;
      valid_in = valid_ff && !job_take;
      if (start && !busy) begin
         valid_in = 1'b1;
         job_in.mode = req_mode;
         job_in.mass_a = req_mass_a;
         job_in.mass_b = req_mass_b;
         job_in.speed_a = req_speed_a;
         job_in.speed_b = req_speed_b;
         job_in.err = !req_all_given || (total == '0);
         job_in.status = !req_all_given ? ST_MISSING
                       : (total == '0) ? ST_ZERO_MASS : ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      job_ff <= job_in;
   end
endmodule
`default_nettype wire

[rtl/core/odcs_back.sv]
`default_nettype none
// Sequencer: multiplies, restoring division (4 quotient bits a cycle), energies, emit.
module odcs_back #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  odcs_pkg::job_type    job,
   input  wire logic            job_valid,
   output logic                 job_take,
   output logic                 rsp_valid,
   output logic [2:0]           rsp_kind,
   output logic [63:0]          rsp_amount,
   output logic [1:0]           rsp_status,
   output logic                 rsp_last
);
   import odcs_pkg::*;
   localparam int SH = 2 * FRAC_BITS + 1;
   localparam logic [3:0] S_IDLE = 4'd0, S_MUL = 4'd1, S_NUM = 4'd2, S_DIV = 4'd3,
      S_SQ = 4'd4, S_KE = 4'd5, S_EMIT = 4'd6, S_ERR = 4'd7, S_SQ2 = 4'd8;

   logic [3:0]   st_ff, st_in;
   job_type      j_ff, j_in;
   // products
   logic signed [66:0] p0_ff, p1_ff, p2_ff, p3_ff;
   logic signed [66:0] p0_in, p1_in, p2_in, p3_in;
   // division: two magnitudes at once
   logic [67:0]  n1_ff, n1_in, n2_ff, n2_in;
   logic [33:0]  r1_ff, r1_in, r2_ff, r2_in;
   logic         g1_ff, g1_in, g2_ff, g2_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic [32:0]  tot;
   logic signed [31:0] f1_ff, f1_in, f2_ff, f2_in;
   logic [63:0]  sq_ff [4], sq_in [4];
   // energy partial products: mass times low and high half of v squared
   logic [64:0]  pp_ff [8], pp_in [8];
   logic [63:0]  kei_ff, kei_in, kef_ff, kef_in, loss_ff, loss_in;
   logic [2:0]   idx_ff, idx_in;
   logic [2:0]   okind; logic [63:0] oamt; logic olast;

   assign tot = {1'b0, j_ff.mass_a} + {1'b0, j_ff.mass_b};

   function automatic logic [31:0] magf(input logic [31:0] v);
      magf = v[31] ? (32'd0 - v) : v;
   endfunction
   function automatic logic signed [31:0] sat32(input logic neg, input logic [67:0] q);
      if (!neg) sat32 = (q > 68'h7FFFFFFF) ? 32'sh7FFFFFFF : q[31:0];
      else sat32 = (q > 68'h80000000) ? 32'sh80000000 : (32'd0 - q[31:0]);
   endfunction
   function automatic logic [63:0] sat64u(input logic [97:0] e);
      sat64u = (e[97:63] != '0) ? 64'h7FFFFFFFFFFFFFFF : e[63:0];
   endfunction

   // four restoring division steps per cycle
   function automatic logic [101:0] dstep(input logic [67:0] n, input logic [33:0] r,
                                          input logic [32:0] d);
      logic [34:0] t;
      logic [67:0] nn;
      logic [33:0] rr;
      nn = n; rr = r;
      for (int k = 0; k < 4; k++) begin
         t = {rr, nn[67]};
         nn = {nn[66:0], 1'b0};
         if (t >= {2'b0, d}) begin
            t = t - {2'b0, d};
            nn[0] = 1'b1;
         end
         rr = t[33:0];
      end
      dstep = {rr, nn};
   endfunction

   logic [101:0] d1, d2;
   logic [97:0]  kei_w, kef_w;
   logic signed [98:0] lw;
   assign d1 = dstep(n1_ff, r1_ff, tot);
   assign d2 = dstep(n2_ff, r2_ff, tot);
   assign kei_w = (((({33'd0, pp_ff[1]} + {33'd0, pp_ff[3]}) << 32)
                  + {33'd0, pp_ff[0]} + {33'd0, pp_ff[2]}) >> SH);
   assign kef_w = (((({33'd0, pp_ff[5]} + {33'd0, pp_ff[7]}) << 32)
                  + {33'd0, pp_ff[4]} + {33'd0, pp_ff[6]}) >> SH);
   assign lw = $signed({1'b0, kei_ff}) - $signed({1'b0, kef_ff});

   assign job_take = (st_ff == S_IDLE) && job_valid;

   always_comb begin
      logic signed [33:0] dm;
      logic signed [66:0] a1, a2;
      st_in = st_ff; j_in = j_ff;
      p0_in = p0_ff; p1_in = p1_ff; p2_in = p2_ff; p3_in = p3_ff;
      n1_in = n1_ff; n2_in = n2_ff; r1_in = r1_ff; r2_in = r2_ff;
      g1_in = g1_ff; g2_in = g2_ff; cnt_in = cnt_ff;
      f1_in = f1_ff; f2_in = f2_ff; sq_in = sq_ff; pp_in = pp_ff;
      kei_in = kei_ff; kef_in = kef_ff; loss_in = loss_ff; idx_in = idx_ff;
      dm = $signed({2'b0, j_ff.mass_a}) - $signed({2'b0, j_ff.mass_b});
      a1 = '0; a2 = '0;
      unique case (st_ff)
         S_IDLE: if (job_valid) begin
            j_in = job;
            st_in = job.err ? S_ERR : S_MUL;
         end
         S_MUL: begin
            if (j_ff.mode) begin
               p0_in = 67'(dm * $signed(j_ff.speed_a));
               p1_in = 67'($signed({1'b0, j_ff.mass_b, 1'b0}) * $signed(j_ff.speed_b));
               p2_in = 67'($signed({1'b0, j_ff.mass_a, 1'b0}) * $signed(j_ff.speed_a));
               p3_in = 67'((-dm) * $signed(j_ff.speed_b));
            end else begin
               p0_in = 67'($signed({1'b0, j_ff.mass_a}) * $signed(j_ff.speed_a));
               p1_in = 67'($signed({1'b0, j_ff.mass_b}) * $signed(j_ff.speed_b));
               p2_in = '0; p3_in = '0;
            end
            sq_in[0] = magf(j_ff.speed_a) * magf(j_ff.speed_a);
            sq_in[1] = magf(j_ff.speed_b) * magf(j_ff.speed_b);
            st_in = S_NUM;
         end
         S_NUM: begin
            a1 = p0_ff + p1_ff; a2 = p2_ff + p3_ff;
            g1_in = a1[66]; g2_in = a2[66];
            n1_in = {1'b0, a1[66] ? (67'd0 - a1) : a1};
            n2_in = {1'b0, a2[66] ? (67'd0 - a2) : a2};
            r1_in = '0; r2_in = '0; cnt_in = '0;
            pp_in[0] = 65'(j_ff.mass_a) * 65'(sq_ff[0][31:0]);
            pp_in[1] = 65'(j_ff.mass_a) * 65'(sq_ff[0][63:32]);
            pp_in[2] = 65'(j_ff.mass_b) * 65'(sq_ff[1][31:0]);
            pp_in[3] = 65'(j_ff.mass_b) * 65'(sq_ff[1][63:32]);
            st_in = S_DIV;
         end
         S_DIV: begin
            n1_in = d1[67:0]; r1_in = d1[101:68];
            n2_in = d2[67:0]; r2_in = d2[101:68];
            cnt_in = cnt_ff + 7'd4;
            if (cnt_ff == 7'd64) begin
               f1_in = sat32(g1_ff, d1[67:0]);
               f2_in = sat32(g2_ff, d2[67:0]);
               st_in = S_SQ;
            end
         end
         S_SQ: begin
            sq_in[2] = magf(f1_ff) * magf(f1_ff);
            sq_in[3] = magf(f2_ff) * magf(f2_ff);
            kei_in = sat64u(kei_w);
            st_in = S_SQ2;
         end
         S_SQ2: begin
            if (j_ff.mode) begin
               pp_in[4] = 65'(j_ff.mass_a) * 65'(sq_ff[2][31:0]);
               pp_in[5] = 65'(j_ff.mass_a) * 65'(sq_ff[2][63:32]);
               pp_in[6] = 65'(j_ff.mass_b) * 65'(sq_ff[3][31:0]);
               pp_in[7] = 65'(j_ff.mass_b) * 65'(sq_ff[3][63:32]);
            end else begin
               pp_in[4] = 65'(tot) * 65'(sq_ff[2][31:0]);
               pp_in[5] = 65'(tot) * 65'(sq_ff[2][63:32]);
               pp_in[6] = '0;
               pp_in[7] = '0;
            end
            st_in = S_KE;
         end
         S_KE: begin
            kef_in = sat64u(kef_w);
            idx_in = '0;
            st_in = S_EMIT;
         end
         S_EMIT: begin
            loss_in = (lw > 99'sh7FFFFFFFFFFFFFFF) ? 64'h7FFFFFFFFFFFFFFF
                    : (lw < -99'sh8000000000000000) ? 64'h8000000000000000 : lw[63:0];
            idx_in = idx_ff + 3'd1;
            if (olast) st_in = S_IDLE;
         end
         S_ERR: st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_comb begin
      okind = KIND_V1; oamt = '0; olast = 1'b0;
      unique case (idx_ff)
         3'd0: begin
            okind = j_ff.mode ? KIND_V1 : KIND_VC;
            oamt = {{32{f1_ff[31]}}, f1_ff};
         end
         3'd1: begin
            okind = j_ff.mode ? KIND_V2 : KIND_KEI;
            oamt = j_ff.mode ? {{32{f2_ff[31]}}, f2_ff} : kei_ff;
         end
         3'd2: begin
            okind = j_ff.mode ? KIND_KEI : KIND_KEF;
            oamt = j_ff.mode ? kei_ff : kef_ff;
         end
         3'd3: begin
            okind = j_ff.mode ? KIND_KEF : KIND_LOSS;
            oamt = j_ff.mode ? kef_ff : loss_ff;
            olast = 1'b1;
         end
         default: olast = 1'b1;
      endcase
   end

   always_comb begin
      rsp_valid = (st_ff == S_EMIT) || (st_ff == S_ERR);
      rsp_kind = (st_ff == S_ERR) ? KIND_V1 : okind;
      rsp_amount = (st_ff == S_ERR) ? 64'd0 : oamt;
      rsp_status = (st_ff == S_ERR) ? j_ff.status : ST_OK;
      rsp_last = (st_ff == S_ERR) ? 1'b1 : olast;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         idx_ff <= '0;
      end else begin
         st_ff <= st_in;
         idx_ff <= idx_in;
      end
      j_ff <= j_in;
      p0_ff <= p0_in; p1_ff <= p1_in; p2_ff <= p2_in; p3_ff <= p3_in;
      n1_ff <= n1_in; n2_ff <= n2_in; r1_ff <= r1_in; r2_ff <= r2_in;
      g1_ff <= g1_in; g2_ff <= g2_in; cnt_ff <= cnt_in;
      f1_ff <= f1_in; f2_ff <= f2_in; sq_ff <= sq_in; pp_ff <= pp_in;
      kei_ff <= kei_in; kef_ff <= kef_in; loss_ff <= loss_in;
   end

   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      job_take |=> (st_ff == S_MUL || st_ff == S_ERR)) else $error("take");
   a_err_single: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_ERR |=> st_ff == S_IDLE) else $error("err");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> st_ff == S_IDLE) else $error("last");
endmodule
`default_nettype wire

[dv/one_dim_collision_solver_tb.sv]
`timescale 1ns / 100ps
module one_dim_collision_solver_tb;
   import odcs_pkg::*;

   typedef struct {
      logic [2:0]  kind;
      logic [63:0] amount;
      logic [1:0]  status;
      logic        last;
   } outcome_type;

   typedef struct {
      logic        mode;
      logic [31:0] mass_a;
      logic [31:0] mass_b;
      logic [31:0] speed_a;
      logic [31:0] speed_b;
      logic        all_given;
      logic        typed;       // row carries a typed-in outcome
      logic [1:0]  typed_status;
   } stim_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        req_mode = 1'b0;
   logic [31:0] req_mass_a = '0;
   logic [31:0] req_mass_b = '0;
   logic [31:0] req_speed_a = '0;
   logic [31:0] req_speed_b = '0;
   logic        req_all_given = 1'b0;
   wire         busy;
   wire         rsp_valid;
   wire  [2:0]  rsp_kind;
   wire  [63:0] rsp_amount;
   wire  [1:0]  rsp_status;
   wire         rsp_last;

   outcome_type pending_results[$];
   int       mismatches = 0;
   int       words_sent = 0;
   int       results_seen = 0;
   int       elastic_words = 0;
   int       error_words = 0;
   int       idle_pct = 0;

   one_dim_collision_solver u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_mass_a(req_mass_a), .req_mass_b(req_mass_b),
      .req_speed_a(req_speed_a), .req_speed_b(req_speed_b),
      .req_all_given(req_all_given), .rsp_valid(rsp_valid), .rsp_kind(rsp_kind),
      .rsp_amount(rsp_amount), .rsp_status(rsp_status), .rsp_last(rsp_last)
   );

   always #6 clock = ~clock;

   function automatic void expect_result(input outcome_type o);
      pending_results.insert(pending_results.size(), o);
   endfunction

   function automatic logic signed [63:0] clamp_speed(logic signed [191:0] q);
      if (q > 192'sd2147483647) begin
         return 64'sd2147483647;
      end else if (q < -192'sd2147483648) begin
         return -64'sd2147483648;
      end
      return q[63:0];
   endfunction

   function automatic logic [63:0] clamp_energy(logic signed [191:0] e);
      if (e > 192'sh7FFFFFFFFFFFFFFF) begin
         return 64'h7FFFFFFFFFFFFFFF;
      end else if (e < -192'sh8000000000000000) begin
         return 64'h8000000000000000;
      end
      return e[63:0];
   endfunction

   // exact sum of m*v*v shifted down by 2*frac+1
   function automatic logic signed [191:0] energy(logic [32:0] ma, logic signed [63:0] va,
                                                  logic [32:0] mb, logic signed [63:0] vb);
      logic signed [191:0] s;
      s = $signed({159'd0, ma}) * va * va + $signed({159'd0, mb}) * vb * vb;
      return s >>> 33;
   endfunction

   task automatic predict_collision(input stim_type s);
      logic [32:0]         total;
      logic signed [191:0] ma, mb, va, vb, n1, n2, ke_i, ke_f;
      logic signed [63:0]  f1, f2;
      total = {1'b0, s.mass_a} + {1'b0, s.mass_b};
      ma = $signed({160'd0, s.mass_a});
      mb = $signed({160'd0, s.mass_b});
      va = {{160{s.speed_a[31]}}, s.speed_a};
      vb = {{160{s.speed_b[31]}}, s.speed_b};
      if (!s.all_given) begin
         expect_result('{KIND_V1, 64'd0, ST_MISSING, 1'b1});
         return;
      end
      if (total == 0) begin
         expect_result('{KIND_V1, 64'd0, ST_ZERO_MASS, 1'b1});
         return;
      end
      ke_i = energy({1'b0, s.mass_a}, va[63:0], {1'b0, s.mass_b}, vb[63:0]);
      if (s.mode) begin
         n1 = (ma - mb) * va + 2 * mb * vb;
         n2 = 2 * ma * va + (mb - ma) * vb;
         f1 = clamp_speed(n1 / $signed({159'd0, total}));
         f2 = clamp_speed(n2 / $signed({159'd0, total}));
         ke_f = energy({1'b0, s.mass_a}, f1, {1'b0, s.mass_b}, f2);
         expect_result('{KIND_V1, f1, ST_OK, 1'b0});
         expect_result('{KIND_V2, f2, ST_OK, 1'b0});
         expect_result('{KIND_KEI, clamp_energy(ke_i), ST_OK, 1'b0});
         expect_result('{KIND_KEF, clamp_energy(ke_f), ST_OK, 1'b1});
      end else begin
         n1 = ma * va + mb * vb;
         f1 = clamp_speed(n1 / $signed({159'd0, total}));
         ke_f = energy(total, f1, 33'd0, 64'sd0);
         expect_result('{KIND_VC, f1, ST_OK, 1'b0});
         expect_result('{KIND_KEI, clamp_energy(ke_i), ST_OK, 1'b0});
         expect_result('{KIND_KEF, clamp_energy(ke_f), ST_OK, 1'b0});
         expect_result('{KIND_LOSS, clamp_energy(ke_i - ke_f), ST_OK, 1'b1});
      end
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected result kind %0d amount %h", rsp_kind, rsp_amount);
            end
         end else begin
            want = pending_results.pop_front();
            if (rsp_kind !== want.kind || rsp_amount !== want.amount ||
                rsp_status !== want.status || rsp_last !== want.last) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: exp kind %0d amt %h st %0d last %0d, got %0d %h %0d %0d",
                           want.kind, want.amount, want.status, want.last,
                           rsp_kind, rsp_amount, rsp_status, rsp_last);
               end
            end
         end
      end
   end

   task automatic send_word(input stim_type s);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      req_mode      <= s.mode;
      req_mass_a    <= s.mass_a;
      req_mass_b    <= s.mass_b;
      req_speed_a   <= s.speed_a;
      req_speed_b   <= s.speed_b;
      req_all_given <= s.all_given;
      start         <= 1'b1;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      if (s.typed) begin
         expect_result('{KIND_V1, 64'd0, s.typed_status, 1'b1});
      end else begin
         predict_collision(s);
      end
      words_sent++;
      if (s.mode && s.all_given) begin
         elastic_words++;
      end
      if (!s.all_given || ({1'b0, s.mass_a} + s.mass_b) == 0) begin
         error_words++;
      end
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_field();
      case ($urandom_range(5))
         0: return 32'h0;
         1: return 32'hFFFFFFFF;
         2: return 32'h80000000;
         3: return $urandom_range(32'h3FFFF);
         4: return {{16{$urandom_range(1) == 1}}, 16'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   stim_type directed[] = '{
      '{1'b1, 32'h10000, 32'h10000, 32'h20000, 32'hFFFF0000, 1'b0, 1'b1, ST_MISSING},
      '{1'b0, 32'h0, 32'h0, 32'h10000, 32'h10000, 1'b0, 1'b1, ST_MISSING},
      '{1'b1, 32'h0, 32'h0, 32'h10000, 32'h10000, 1'b1, 1'b1, ST_ZERO_MASS},
      '{1'b0, 32'h0, 32'h0, 32'h7FFFFFFF, 32'h80000000, 1'b1, 1'b1, ST_ZERO_MASS},
      '{1'b1, 32'h10000, 32'h10000, 32'h20000, 32'hFFFF0000, 1'b1, 1'b0, ST_OK},
      '{1'b0, 32'h10000, 32'h10000, 32'h20000, 32'hFFFF0000, 1'b1, 1'b0, ST_OK},
      '{1'b1, 32'hFFFFFFFF, 32'h1, 32'h7FFFFFFF, 32'h80000000, 1'b1, 1'b0, ST_OK},
      '{1'b1, 32'h1, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000, 1'b1, 1'b0, ST_OK},
      '{1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h80000000, 32'h80000000, 1'b1, 1'b0, ST_OK},
      '{1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1, 1'b0, ST_OK},
      '{1'b0, 32'h0, 32'h1, 32'h80000000, 32'h7FFFFFFF, 1'b1, 1'b0, ST_OK},
      '{1'b1, 32'h0, 32'h1, 32'h80000000, 32'h7FFFFFFF, 1'b1, 1'b0, ST_OK},
      '{1'b0, 32'h3, 32'h0, 32'h1, 32'hFFFFFFFF, 1'b1, 1'b0, ST_OK},
      '{1'b0, 32'h30000, 32'h10000, 32'h1, 32'h0, 1'b1, 1'b0, ST_OK},
      '{1'b1, 32'h20000, 32'h10000, 32'hFFFFFFFF, 32'h1, 1'b1, 1'b0, ST_OK},
      '{1'b0, 32'hFFFFFFFF, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0, ST_OK}
   };

   initial begin
      stim_type s;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed[i]) begin
         send_word(directed[i]);
      end
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 36 : (phase == 1) ? 48 : 0;
         for (int n = 0; n < 148; n++) begin
            s.mode = $urandom_range(1);
            s.mass_a = pick_field();
            s.mass_b = ($urandom_range(19) == 0) ? 32'h0 : pick_field();
            s.speed_a = pick_field();
            s.speed_b = pick_field();
            s.all_given = ($urandom_range(15) != 0);
            s.typed = 1'b0;
            s.typed_status = ST_OK;
            send_word(s);
            if (n == 70) begin
               // hold off until the pipe drains
               start <= 1'b0;
               while (pending_results.size() != 0) begin
                  @(negedge clock);
               end
            end
         end
      end
      start <= 1'b0;
      while (pending_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (80) @(negedge clock);
      $display("%0d words sent (%0d elastic, %0d error cases), %0d results checked",
               words_sent, elastic_words, error_words, results_seen);
      $display("mismatches: %0d, leftover expectations: %0d",
               mismatches, pending_results.size());
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("FAILED: results differ");
      $finish;
   end
endmodule
